@@ hw/rtl/cbel_pkg.sv @@
// ----------------------------------------------------------------------------
// cbel_pkg
// Shared types and constants for the cubic Bezier evaluator and length unit.
// ----------------------------------------------------------------------------
package cbel_pkg;

   localparam int NUM_POINTS   = 4;
   localparam int COORD_BITS   = 16;
   localparam int REG_BITS     = 48;

   localparam logic [6:0]  MAX_SEGMENTS = 7'd100;
   localparam logic [16:0] T_ONE        = 17'd65536;
   localparam logic [18:0] LEN_MAX      = 19'd524287;

   localparam logic CMD_EVAL   = 1'b0;
   localparam logic CMD_LENGTH = 1'b1;

   // multiplier sequence steps
   localparam logic [4:0] MS_TT        = 5'd0;
   localparam logic [4:0] MS_BB        = 5'd1;
   localparam logic [4:0] MS_W0        = 5'd2;
   localparam logic [4:0] MS_W1        = 5'd3;
   localparam logic [4:0] MS_W2        = 5'd4;
   localparam logic [4:0] MS_W3        = 5'd5;
   localparam logic [4:0] MS_DOT_FIRST = 5'd6;
   localparam logic [4:0] MS_DOT_LAST  = 5'd17;
   localparam logic [4:0] MS_SQ_FIRST  = 5'd18;
   localparam logic [4:0] MS_SQ_LAST   = 5'd20;

   localparam logic [4:0] DIV_LAST = 5'd22;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_SQRT,
      ST_ACCUM
   } state_type;

endpackage

@@ hw/rtl/cubic_bezier_eval_and_length.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_eval_and_length
// Evaluates a cubic Bezier point at t, or refines a polyline arc length.
//
//   channel   ports                         handshake
//   request   req_command, req_param_t      start & !busy
//   response  rsp_point_*, rsp_curve_length, rsp_valid, one cycle
//             rsp_step_limit_hit, rsp_steps_used
//   config    csr_write_enable/index/wdata  csr_write_enable
//
// Evaluate forms 18 products on one shared 36x18 multiplier. Length
// runs, for each sample point, a divider for t, 18 products, 3 squares and
// a square root, summed over n+1 points for each pass n, up to 100 passes.
// Reset is synchronous and clears control state and control points.
// The response cannot be stalled; busy is high until it is issued.
// ----------------------------------------------------------------------------
module cubic_bezier_eval_and_length
   import cbel_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [16:0]        req_param_t,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_point_x,
   output logic signed [15:0] rsp_point_y,
   output logic signed [15:0] rsp_point_z,
   output logic [18:0]        rsp_curve_length,
   output logic               rsp_step_limit_hit,
   output logic [6:0]         rsp_steps_used
);

   state_type state_ff, state_in;

   logic [REG_BITS-1:0] pts_ff [NUM_POINTS];

   logic               cmd_ff, cmd_in;
   logic [16:0]        t_ff, t_in;
   logic [6:0]         n_ff, n_in;
   logic [6:0]         i_ff, i_in;
   logic [18:0]        guess_ff, guess_in;
   logic [18:0]        sum_ff, sum_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [4:0]         mstep_ff, mstep_in;
   logic               phase_ff, phase_in;
   logic signed [53:0] prod_ff, prod_in;
   logic [33:0]        tt_ff, tt_in;
   logic [33:0]        bb_ff, bb_in;
   logic [32:0]        wq_ff [NUM_POINTS];
   logic [32:0]        wq_in [NUM_POINTS];
   logic signed [51:0] acc_ff, acc_in;
   logic signed [17:0] p_ff [3];
   logic signed [17:0] p_in [3];
   logic signed [17:0] prev_ff [3];
   logic signed [17:0] prev_in [3];
   logic [34:0]        sq_ff, sq_in;
   logic [22:0]        num_ff, num_in;
   logic [6:0]         rem_ff, rem_in;
   logic [34:0]        sv_ff, sv_in;
   logic [35:0]        sr_ff, sr_in;
   logic [34:0]        sbit_ff, sbit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic signed [15:0] rsp_z_ff, rsp_z_in;
   logic [18:0]        rsp_len_ff, rsp_len_in;
   logic               rsp_lim_ff, rsp_lim_in;
   logic [6:0]         rsp_steps_ff, rsp_steps_in;

   logic [16:0]        bv;
   logic signed [35:0] mul_a;
   logic signed [17:0] mul_b;
   logic [3:0]         dot_j;
   logic [1:0]         widx;
   logic [1:0]         kidx;
   logic [1:0]         sqk;
   logic [15:0]        coord;
   logic signed [17:0] dd [3];
   logic [49:0]        w_base;
   logic [49:0]        w_round;
   logic signed [51:0] acc_sum;
   logic [51:0]        acc_abs;
   logic [51:0]        acc_rnd;
   logic [17:0]        acc_mag;
   logic signed [17:0] coord_new;
   logic [7:0]         rem_sh;
   logic               qbit;
   logic [35:0]        sr_try;
   logic [17:0]        sq_root;
   logic [19:0]        sum_wide;
   logic [18:0]        sum_sat;
   logic signed [19:0] gain;
   logic signed [26:0] gain100;
   logic               stop_pass;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign busy = (state_ff != ST_IDLE);

   // shared multiplier operands
   always_comb begin
      bv    = T_ONE - t_ff;
      dot_j = 4'(mstep_ff - MS_DOT_FIRST);
      widx  = dot_j[1:0];
      kidx  = dot_j[3:2];
      sqk   = 2'(mstep_ff - MS_SQ_FIRST);
      coord = pts_ff[widx][kidx*COORD_BITS +: COORD_BITS];
      for (int k = 0; k < 3; k++) begin
         dd[k] = p_ff[k] - prev_ff[k];
      end
      mul_a = '0;
      mul_b = '0;
      case (mstep_ff) inside
         MS_TT: begin
            mul_a = $signed({19'd0, t_ff});
            mul_b = $signed({1'b0, t_ff});
         end
         MS_BB: begin
            mul_a = $signed({19'd0, bv});
            mul_b = $signed({1'b0, bv});
         end
         MS_W0: begin
            mul_a = $signed({2'd0, tt_ff});
            mul_b = $signed({1'b0, t_ff});
         end
         MS_W1: begin
            mul_a = $signed({2'd0, tt_ff});
            mul_b = $signed({1'b0, bv});
         end
         MS_W2: begin
            mul_a = $signed({2'd0, bb_ff});
            mul_b = $signed({1'b0, t_ff});
         end
         MS_W3: begin
            mul_a = $signed({2'd0, bb_ff});
            mul_b = $signed({1'b0, bv});
         end
         [MS_DOT_FIRST:MS_DOT_LAST]: begin
            mul_a = $signed({3'd0, wq_ff[widx]});
            mul_b = $signed({{2{coord[15]}}, coord});
         end
         [MS_SQ_FIRST:MS_SQ_LAST]: begin
            mul_a = $signed({{18{dd[sqk][17]}}, dd[sqk]});
            mul_b = dd[sqk];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // datapath helpers
   always_comb begin
      if (mstep_ff == MS_W1 || mstep_ff == MS_W2) begin
         w_base = {prod_ff[48:0], 1'b0} + {1'b0, prod_ff[48:0]};
      end else begin
         w_base = {1'b0, prod_ff[48:0]};
      end
      w_round = w_base + 50'd32768;

      acc_sum = acc_ff + 52'(prod_ff);
      acc_abs = acc_sum[51] ? 52'(-acc_sum) : 52'(acc_sum);
      acc_rnd = acc_abs + 52'h0_0000_8000_0000;
      acc_mag = acc_rnd[49:32];
      coord_new = acc_sum[51] ? -$signed(acc_mag) : $signed(acc_mag);

      rem_sh = {rem_ff, num_ff[22]};
      qbit   = (rem_sh >= {1'b0, n_ff});

      sr_try  = sr_ff + {1'b0, sbit_ff};
      sq_root = sr_ff[17:0] + 18'({17'd0, ({1'b0, sv_ff} > sr_ff)});

      sum_wide = {1'b0, sum_ff} + {2'd0, sq_root};
      sum_sat  = (sum_wide > {1'b0, LEN_MAX}) ? LEN_MAX : sum_wide[18:0];
      gain     = $signed({1'b0, sum_sat}) - $signed({1'b0, guess_ff});
      gain100  = 27'(gain) * 27'sd100;
      stop_pass = (sum_sat == guess_ff) ||
                  ((guess_ff != '0) && (gain100 < $signed({8'd0, guess_ff})));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      guess_in     = guess_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      mstep_in     = mstep_ff;
      phase_in     = phase_ff;
      tt_in        = tt_ff;
      bb_in        = bb_ff;
      wq_in        = wq_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      sq_in        = sq_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      sv_in        = sv_ff;
      sr_in        = sr_ff;
      sbit_in      = sbit_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_lim_in   = rsp_lim_ff;
      rsp_steps_in = rsp_steps_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               if (req_command == CMD_EVAL) begin
                  t_in     = (req_param_t > T_ONE) ? T_ONE : req_param_t;
                  mstep_in = MS_TT;
                  phase_in = 1'b0;
                  acc_in   = '0;
                  state_in = ST_MULTIPLY;
               end else begin
                  n_in     = 7'd1;
                  i_in     = '0;
                  guess_in = '0;
                  sum_in   = '0;
                  state_in = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            rem_in = qbit ? 7'(rem_sh - {1'b0, n_ff}) : rem_sh[6:0];
            num_in = {num_ff[21:0], qbit};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               t_in     = num_in[16:0];
               mstep_in = MS_TT;
               phase_in = 1'b0;
               acc_in   = '0;
               state_in = ST_MULTIPLY;
            end
         end

         ST_MULTIPLY: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               mstep_in = mstep_ff + 5'd1;
               case (mstep_ff) inside
                  MS_TT: tt_in = prod_ff[33:0];
                  MS_BB: bb_in = prod_ff[33:0];
                  [MS_W0:MS_W3]: wq_in[2'(mstep_ff - MS_W0)] = w_round[48:16];
                  [MS_DOT_FIRST:MS_DOT_LAST]: begin
                     if (widx == 2'd3) begin
                        p_in[kidx] = coord_new;
                        acc_in     = '0;
                     end else begin
                        acc_in = acc_sum;
                     end
                  end
                  default: sq_in = sq_ff + prod_ff[34:0];
               endcase
               if (mstep_ff == MS_DOT_LAST) begin
                  if (cmd_ff == CMD_EVAL) begin
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = sat16(p_in[0]);
                     rsp_y_in     = sat16(p_in[1]);
                     rsp_z_in     = sat16(p_in[2]);
                     rsp_len_in   = '0;
                     rsp_lim_in   = 1'b0;
                     rsp_steps_in = '0;
                     state_in     = ST_IDLE;
                  end else if (i_ff == '0) begin
                     prev_in  = p_in;
                     i_in     = 7'd1;
                     state_in = ST_DIVIDE;
                  end else begin
                     sq_in = '0;
                  end
               end
               if (mstep_ff == MS_SQ_LAST) begin
                  sv_in    = sq_ff + prod_ff[34:0];
                  sr_in    = '0;
                  sbit_in  = 35'(1) << 34;
                  state_in = ST_SQRT;
               end
            end
         end

         ST_SQRT: begin
            if ({1'b0, sv_ff} >= sr_try) begin
               sv_in = 35'({1'b0, sv_ff} - sr_try);
               sr_in = (sr_ff >> 1) + {1'b0, sbit_ff};
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               state_in = ST_ACCUM;
            end
         end

         ST_ACCUM: begin
            sum_in  = sum_sat;
            prev_in = p_ff;
            if (i_ff != n_ff) begin
               i_in     = i_ff + 7'd1;
               state_in = ST_DIVIDE;
            end else if (stop_pass || n_ff == MAX_SEGMENTS) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_len_in   = sum_sat;
               rsp_lim_in   = ~stop_pass;
               rsp_steps_in = n_ff;
               state_in     = ST_IDLE;
            end else begin
               guess_in = sum_sat;
               sum_in   = '0;
               n_in     = n_ff + 7'd1;
               i_in     = '0;
               state_in = ST_DIVIDE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // load the divider for t = round(i * 65536 / n)
      if (state_in == ST_DIVIDE && state_ff != ST_DIVIDE) begin
         num_in = {i_in, 16'd0} + {17'd0, n_in[6:1]};
         rem_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_POINTS; k++) begin
            pts_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && csr_index < 3'(NUM_POINTS)) begin
            pts_ff[csr_index[1:0]] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      t_ff         <= t_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      guess_ff     <= guess_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      mstep_ff     <= mstep_in;
      phase_ff     <= phase_in;
      prod_ff      <= prod_in;
      tt_ff        <= tt_in;
      bb_ff        <= bb_in;
      wq_ff        <= wq_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      prev_ff      <= prev_in;
      sq_ff        <= sq_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      sv_ff        <= sv_in;
      sr_ff        <= sr_in;
      sbit_ff      <= sbit_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_lim_ff   <= rsp_lim_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_x        = rsp_x_ff;
   assign rsp_point_y        = rsp_y_ff;
   assign rsp_point_z        = rsp_z_ff;
   assign rsp_curve_length   = rsp_len_ff;
   assign rsp_step_limit_hit = rsp_lim_ff;
   assign rsp_steps_used     = rsp_steps_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cubic_bezier_eval_and_length. Control points are
// loaded through the CSR port while the unit is idle; a directed table covers
// reset values, parameter extremes, t above one, ignored register indexes and
// a degenerate curve, then random evaluate and length transactions follow
// under several point settings. Every response is checked field by field
// against a table entry or a bit-exact Bezier and polyline-length predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import cbel_pkg::*;
;

   localparam int WATCHDOG_CYCLES = 2000000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [18:0]        len;
      logic               hit;
      logic [6:0]         steps;
   } bez_result_type;

   typedef struct {
      logic           cmd;
      logic [16:0]    t;
      bit             typed;
      bez_result_type res;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = 1'b0;
   logic [16:0]        req_param_t = '0;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [47:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_point_x;
   logic signed [15:0] rsp_point_y;
   logic signed [15:0] rsp_point_z;
   logic [18:0]        rsp_curve_length;
   logic               rsp_step_limit_hit;
   logic [6:0]         rsp_steps_used;

   logic [47:0]     ctrl_pts [NUM_POINTS];
   bez_result_type  pending_results [$];
   int              mismatches = 0;
   int              idle_cycles = 0;
   int              n_eval = 0;
   int              n_length = 0;
   int              n_limit = 0;
   bit              allow_gaps = 1'b1;

   cubic_bezier_eval_and_length DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint eval_axis(longint unsigned t, int k);
      longint unsigned b, wq;
      longint unsigned w [4];
      longint acc;
      b = 64'd65536 - t;
      w[0] = t * t * t;
      w[1] = 3 * t * t * b;
      w[2] = 3 * t * b * b;
      w[3] = b * b * b;
      acc = 0;
      for (int i = 0; i < 4; i++) begin
         wq = (w[i] + 64'd32768) >> 16;
         acc += longint'(wq) * longint'($signed(ctrl_pts[i][k*16 +: 16]));
      end
      if (acc >= 0) return (acc + 64'sd2147483648) >>> 32;
      return -(((-acc) + 64'sd2147483648) >>> 32);
   endfunction

   function automatic longint unsigned root_nearest(longint unsigned v);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      if (v > r) r++;
      return r;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic bez_result_type predict_bezier(logic cmd, logic [16:0] t_in);
      bez_result_type r;
      longint unsigned t, n, guess, sum, d, sq;
      longint p [3];
      longint prev [3];
      longint dd;
      r = '{default: '0};
      if (cmd == CMD_EVAL) begin
         t = (t_in > T_ONE) ? 64'd65536 : t_in;
         r.x = clamp16(eval_axis(t, 0));
         r.y = clamp16(eval_axis(t, 1));
         r.z = clamp16(eval_axis(t, 2));
         return r;
      end
      guess = 0;
      for (n = 1; ; n++) begin
         if (n > MAX_SEGMENTS) begin
            r.len = guess[18:0];
            r.hit = 1'b1;
            r.steps = MAX_SEGMENTS;
            return r;
         end
         sum = 0;
         for (longint unsigned i = 0; i <= n; i++) begin
            t = (i * 65536 + n / 2) / n;
            for (int k = 0; k < 3; k++) p[k] = eval_axis(t, k);
            if (i != 0) begin
               sq = 0;
               for (int k = 0; k < 3; k++) begin
                  dd = p[k] - prev[k];
                  if (dd < 0) dd = -dd;
                  sq += dd * dd;
               end
               d = root_nearest(sq);
               sum = (sum + d > LEN_MAX) ? LEN_MAX : sum + d;
            end
            prev = p;
         end
         if (sum == guess ||
             (guess > 0 && 100 * (longint'(sum) - longint'(guess)) < longint'(guess))) begin
            r.len = sum[18:0];
            r.steps = n[6:0];
            return r;
         end
         guess = sum;
      end
   endfunction

   always @(posedge clock) begin
      bez_result_type got, want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("FAIL cubic_bezier_eval_and_length");
            $finish;
         end
         if (rsp_valid) begin
            got = '{rsp_point_x, rsp_point_y, rsp_point_z, rsp_curve_length,
                    rsp_step_limit_hit, rsp_steps_used};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = pending_results.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.len !== want.len || got.hit !== want.hit ||
                   got.steps !== want.steps) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
      end
   end

   task automatic gap_maybe();
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic issue(logic cmd, logic [16:0] t, bit typed, bez_result_type typed_res);
      bez_result_type pr;
      start <= 1'b1;
      req_command <= cmd;
      req_param_t <= t;
      do @(posedge clock); while (busy !== 1'b0);
      pr = predict_bezier(cmd, t);
      pending_results.push_back(typed ? typed_res : pr);
      if (cmd == CMD_EVAL) n_eval++;
      else begin
         n_length++;
         if (pr.hit) n_limit++;
      end
      gap_maybe();
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic load_points(logic [47:0] p0, logic [47:0] p1, logic [47:0] p2,
                              logic [47:0] p3);
      logic [47:0] vals [4];
      vals = '{p0, p1, p2, p3};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         ctrl_pts[i] = vals[i];
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [47:0] rand_point(int mode);
      logic [47:0] v;
      int span;
      v = {$urandom, $urandom};
      if (mode == 0) begin
         span = $urandom_range(16, 2048);
         for (int k = 0; k < 3; k++)
            v[k*16 +: 16] = 16'($urandom_range(0, 2 * span) - span);
      end else if (mode == 2) begin
         for (int k = 0; k < 3; k++)
            v[k*16 +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      return v;
   endfunction

   function automatic logic [16:0] rand_t();
      case ($urandom_range(0, 9))
         0: return 17'($urandom_range(65537, 131071));
         1: return $urandom_range(0, 1) ? 17'd0 : T_ONE;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   stim_row_type zero_rows [5];
   stim_row_type ext_rows [8];

   initial begin
      bez_result_type zr, mx, mn;
      logic [47:0] same;
      int mode;
      for (int i = 0; i < 4; i++) ctrl_pts[i] = '0;
      zr = '{default: '0};
      mx = '{16'sd32767, 16'sd32767, 16'sd32767, 19'd0, 1'b0, 7'd0};
      mn = '{-16'sd32768, -16'sd32768, -16'sd32768, 19'd0, 1'b0, 7'd0};
      zero_rows = '{
         '{CMD_EVAL,   17'd0,      1'b1, zr},
         '{CMD_EVAL,   T_ONE,      1'b1, zr},
         '{CMD_EVAL,   17'h1FFFF,  1'b1, zr},
         '{CMD_EVAL,   17'd32768,  1'b1, zr},
         '{CMD_LENGTH, 17'h1FFFF,  1'b1, '{0, 0, 0, 19'd0, 1'b0, 7'd1}}
      };
      ext_rows = '{
         '{CMD_EVAL,   17'd0,      1'b1, mn},
         '{CMD_EVAL,   T_ONE,      1'b1, mx},
         '{CMD_EVAL,   17'h1FFFF,  1'b1, mx},
         '{CMD_EVAL,   17'd65537,  1'b1, mx},
         '{CMD_EVAL,   17'd1,      1'b0, zr},
         '{CMD_EVAL,   17'd65535,  1'b0, zr},
         '{CMD_EVAL,   17'd32768,  1'b0, zr},
         '{CMD_LENGTH, 17'd0,      1'b0, zr}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (zero_rows[i]) issue(zero_rows[i].cmd, zero_rows[i].t, zero_rows[i].typed,
                                   zero_rows[i].res);
      drain();
      for (int i = 4; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= {$urandom, $urandom} | 48'h1;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      issue(CMD_LENGTH, 17'd0, 1'b1, zero_rows[4].res);
      issue(CMD_EVAL, 17'd40000, 1'b1, zr);
      drain();

      load_points(48'h7FFF_7FFF_7FFF, rand_point(1), rand_point(1), 48'h8000_8000_8000);
      foreach (ext_rows[i]) issue(ext_rows[i].cmd, ext_rows[i].t, ext_rows[i].typed,
                                  ext_rows[i].res);
      drain();

      same = rand_point(1);
      load_points(same, same, same, same);
      issue(CMD_LENGTH, 17'd5, 1'b1, zero_rows[4].res);
      issue(CMD_EVAL, 17'd0, 1'b1,
            '{$signed(same[15:0]), $signed(same[31:16]), $signed(same[47:32]), 0, 0, 0});
      issue(CMD_EVAL, 17'd21845, 1'b0, zr);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         mode = (ph == 3) ? 2 : ph % 2;
         allow_gaps = (ph != 4);
         load_points(rand_point(mode), rand_point(mode), rand_point(mode), rand_point(mode));
         for (int i = 0; i < 20; i++)
            issue($urandom_range(0, 5) == 0 ? CMD_LENGTH : CMD_EVAL, rand_t(), 1'b0, zr);
         drain();
      end

      repeat (100) @(posedge clock);
      $display("covered %0d evaluate and %0d length transactions (%0d at segment limit)",
               n_eval, n_length, n_limit);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS cubic_bezier_eval_and_length");
      end else begin
         $display("FAIL cubic_bezier_eval_and_length");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/cbel_pkg.sv
hw/rtl/cubic_bezier_eval_and_length.sv
test/tb_top.sv
